FILE: rtl/ftg_pkg.sv
// Package: shared constants, types and sine polynomial constants for the trajectory generator.
`timescale 1ns / 1ps
package ftg_pkg;
	localparam int MaxHarmonicsDefault = 16;
	localparam int SineAddrBitsDefault = 10;

	localparam logic [1:0] FUNC_EVAL  = 2'd0;
	localparam logic [1:0] FUNC_WR_COS = 2'd1;
	localparam logic [1:0] FUNC_WR_SIN = 2'd2;

	localparam logic [2:0] REG_PHASE_STEP = 3'd0;
	localparam logic [2:0] REG_OMEGA      = 3'd1;
	localparam logic [2:0] REG_INV_OMEGA  = 3'd2;
	localparam logic [2:0] REG_OFFSET     = 3'd3;
	localparam logic [2:0] REG_HCOUNT     = 3'd4;

	localparam logic [31:0] ONE_Q30 = 32'd1073741824;
	localparam logic [31:0] PC1  = 32'd1686629713;
	localparam logic [31:0] PC3  = 32'd693598668;
	localparam logic [31:0] PC5  = 32'd85569306;
	localparam logic [31:0] PC7  = 32'd5026995;
	localparam logic [31:0] PC9  = 32'd172272;
	localparam logic [31:0] PC11 = 32'd3864;

	typedef struct packed {
		logic [31:0] phase_step;
		logic [31:0] omega;
		logic [31:0] inv_omega;
		logic [31:0] offset;
		logic [4:0]  hcount;
	} cfg_t;
endpackage

FILE: rtl/ftg_if.sv
// Interfaces: input item channel and result channel.
`timescale 1ns / 1ps
interface ftg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [3:0]  coef_index;
	logic signed [31:0] coef_value;
	logic [31:0] tick_count;
	modport source (output valid, func, coef_index, coef_value, tick_count, input ready);
	modport sink (input valid, func, coef_index, coef_value, tick_count, output ready);
endinterface

interface ftg_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] position;
	logic signed [31:0] velocity;
	logic signed [31:0] acceleration;
	logic        saturated;
	modport source (output valid, position, velocity, acceleration, saturated, input ready);
	modport sink (input valid, position, velocity, acceleration, saturated, output ready);
endinterface

FILE: rtl/ftg_sine.sv
// Quarter-wave sine/cosine: one polynomial step per cycle, iterated over a shared multiplier.
`timescale 1ns / 1ps
module ftg_sine import ftg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] x_in,
	output logic        done,
	output logic [31:0] y
);
	// steps: 0 x2, 1..5 horner, 6 final
	logic [2:0]  step_q;
	logic        busy_q;
	logic [31:0] x_q, x2_q, r_q;
	logic [31:0] mul_a, mul_b, coef;
	logic [63:0] prod;
	logic [31:0] prod_sh;

	always_comb begin
		unique case (step_q)
			3'd1: coef = PC9;
			3'd2: coef = PC7;
			3'd3: coef = PC5;
			3'd4: coef = PC3;
			default: coef = PC1;
		endcase
		mul_a = x2_q;
		mul_b = r_q;
		if (step_q == 3'd0) begin
			mul_a = x_q;
			mul_b = x_q;
		end else if (step_q == 3'd6) begin
			mul_a = x_q;
			mul_b = r_q;
		end
		prod = {32'd0, mul_a} * {32'd0, mul_b};
		prod_sh = prod[61:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd6) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_in;
			r_q <= PC11;
		end else if (busy_q) begin
			if (step_q == 3'd0)
				x2_q <= prod_sh;
			else if (step_q == 3'd6)
				y <= (prod_sh > ONE_Q30) ? ONE_Q30 : prod_sh;
			else
				r_q <= coef - prod_sh;
		end
	end
endmodule

FILE: rtl/ftg_coef_mem.sv
// Coefficient memory: cosine and sine tables with registered read, per-entry valid bits for cleared reset.
`timescale 1ns / 1ps
module ftg_coef_mem import ftg_pkg::*; #(
	parameter int MAX_HARMONICS = MaxHarmonicsDefault,
	localparam int AW = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic          wr_sin,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_cos,
	output logic [31:0]   rd_sin
);
	logic [31:0] cos_mem [MAX_HARMONICS];
	logic [31:0] sin_mem [MAX_HARMONICS];
	logic [MAX_HARMONICS-1:0] cv_q, sv_q;
	logic [31:0] cos_rd, sin_rd;
	logic        cv_rd, sv_rd;

	always_ff @(posedge clk) begin
		if (wr_en && !wr_sin)
			cos_mem[wr_addr] <= wr_data;
		if (wr_en && wr_sin)
			sin_mem[wr_addr] <= wr_data;
		cos_rd <= cos_mem[rd_addr];
		sin_rd <= sin_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q  <= '0;
			sv_q  <= '0;
			cv_rd <= 1'b0;
			sv_rd <= 1'b0;
		end else begin
			if (wr_en && !wr_sin)
				cv_q[wr_addr] <= 1'b1;
			if (wr_en && wr_sin)
				sv_q[wr_addr] <= 1'b1;
			cv_rd <= cv_q[rd_addr];
			sv_rd <= sv_q[rd_addr];
		end
	end

	assign rd_cos = cv_rd ? cos_rd : 32'd0;
	assign rd_sin = sv_rd ? sin_rd : 32'd0;
endmodule

FILE: rtl/ftg_div.sv
// Signed-by-small-unsigned restoring divider, one quotient bit per cycle, truncates toward zero.
`timescale 1ns / 1ps
module ftg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic [5:0]         den,
	output logic               done,
	output logic signed [63:0] quo
);
	logic [63:0] n_q, q_q;
	logic [6:0]  rem_q;
	logic        neg_q, busy_q;
	logic [5:0]  cnt_q, den_q;
	logic [6:0]  trial;

	assign trial = {rem_q[5:0], n_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[63];
			n_q   <= num[63] ? (64'd0 - num) : num;
			rem_q <= '0;
			q_q   <= '0;
			den_q <= den;
		end else if (busy_q) begin
			n_q <= {n_q[62:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? (64'sd0 - $signed(q_q)) : $signed(q_q);
endmodule

FILE: rtl/fourier_trajectory_generator_unit.sv
// Top level: Fourier-series trajectory generator with coefficient memory and sequencer.
//
//  channel   dir  beat contents
//  in        in   func, coef_index, coef_value, tick_count
//  out       out  position, velocity, acceleration, saturated
//  cfg       in   cfg_we, cfg_index, cfg_data (plain write, no handshake)
//
// A write item is taken without leaving idle. An evaluate item walks the harmonics one at a time:
// memory read, two polynomial sine passes and the 64-step divider for the position term
// dominate each harmonic, and a finishing state (S_DONE) registers the result.
// Reset loads the config defaults and clears the coefficient valid bits; no clearing pass.
// in.ready drops while an evaluation runs or a result waits in the output register.
`timescale 1ns / 1ps
module fourier_trajectory_generator_unit import ftg_pkg::*; #(
	parameter int MAX_HARMONICS = MaxHarmonicsDefault,
	parameter int SINE_TABLE_ADDR_BITS = SineAddrBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	ftg_in_if.sink      in,
	ftg_out_if.source   out
);
	localparam int AW = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
	localparam int HW = $clog2(MAX_HARMONICS + 1);
	localparam int SB = SINE_TABLE_ADDR_BITS;
	localparam logic [5:0] MAXH = 6'(MAX_HARMONICS);

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_SIN0, S_SIN1, S_MUL, S_MUL2, S_DIV, S_ACC, S_NEXT, S_DONE, S_OUT
	} state_t;

	cfg_t cfg_q;
	state_t state_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= '0;
			cfg_q.omega      <= 32'd16777216;
			cfg_q.inv_omega  <= 32'd16777216;
			cfg_q.offset     <= '0;
			cfg_q.hcount     <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PHASE_STEP: cfg_q.phase_step <= cfg_data;
				REG_OMEGA:      cfg_q.omega      <= cfg_data;
				REG_INV_OMEGA:  cfg_q.inv_omega  <= cfg_data;
				REG_OFFSET:     cfg_q.offset     <= cfg_data;
				REG_HCOUNT:     cfg_q.hcount     <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	logic acc_in;
	assign in.ready = (state_q == S_IDLE);
	assign acc_in = in.valid && in.ready;

	// coefficient memory
	logic          wr_en;
	logic [AW-1:0] rd_addr;
	logic [31:0]   a_rd, b_rd;
	assign wr_en = acc_in && (in.func == FUNC_WR_COS || in.func == FUNC_WR_SIN)
		&& ({2'b00, in.coef_index} < MAXH);

	ftg_coef_mem #(.MAX_HARMONICS(MAX_HARMONICS)) u_mem (
		.clk, .arst_n, .wr_en, .wr_sin(in.func == FUNC_WR_SIN),
		.wr_addr(AW'(in.coef_index)), .wr_data(in.coef_value),
		.rd_addr, .rd_cos(a_rd), .rd_sin(b_rd)
	);

	// per-harmonic registers
	logic [HW-1:0] h_q, n_q;
	logic [31:0]   k_q, hk_q, phase_q;
	logic signed [31:0] a_q, b_q;
	logic signed [31:0] s_q, c_q;
	logic signed [63:0] vsum_q, psum_q, asum_q;
	logic signed [63:0] pa_q, pb_q, pc_q, pd_q;
	logic signed [63:0] tp_q, ta_q;

	assign rd_addr = AW'(h_q - HW'(1));

	// table address of the current phase: quadrant on top, position in quadrant below
	logic [SB-1:0] p_idx;
	logic [31:0]   x_w;
	assign p_idx = phase_q[31 -: SB];
	assign x_w = {2'b00, p_idx[SB-3:0], {(32-SB){1'b0}}};

	// sine unit, used twice per harmonic; phase_q holds steady across both passes
	logic        sn_start, sn_done;
	logic [31:0] sn_x, sn_y;
	logic        sel_c_q;
	logic        sel_busy_q;
	ftg_sine u_sine (.clk, .arst_n, .start(sn_start), .x_in(sn_x), .done(sn_done), .y(sn_y));

	logic [1:0] qsel;
	assign qsel = p_idx[SB-1 -: 2] + {1'b0, sel_c_q};
	assign sn_x = qsel[0] ? (ONE_Q30 - x_w) : x_w;

	// divider
	logic        dv_start, dv_done;
	logic signed [63:0] dv_q;
	ftg_div u_div (.clk, .arst_n, .start(dv_start), .num(tp_q),
		.den(6'(h_q)), .done(dv_done), .quo(dv_q));

	logic signed [63:0] fs32_p, fs32_a, vel_t;
	assign vel_t  = (pa_q + pb_q) >>> 22;
	assign fs32_p = (pc_q - pd_q) >>> 32;
	assign fs32_a = (pd_q - pc_q) >>> 32;

	logic signed [63:0] psh, vsh, ash;
	logic [31:0] pos_w, vel_w, accn_w;
	logic p_c, v_c, a_c;
	assign psh = psum_q >>> 16;
	assign vsh = vsum_q >>> 16;
	assign ash = asum_q >>> 16;
	always_comb begin
		p_c = (psh > 64'sd2147483647) || (psh < -64'sd2147483648);
		v_c = (vsh > 64'sd2147483647) || (vsh < -64'sd2147483648);
		a_c = (ash > 64'sd2147483647) || (ash < -64'sd2147483648);
		pos_w  = p_c ? (psh[63] ? 32'h80000000 : 32'h7fffffff) : psh[31:0];
		vel_w  = v_c ? (vsh[63] ? 32'h80000000 : 32'h7fffffff) : vsh[31:0];
		accn_w = a_c ? (ash[63] ? 32'h80000000 : 32'h7fffffff) : ash[31:0];
	end

	assign sn_start = (state_q == S_SIN0 || state_q == S_SIN1) && !sel_busy_q;
	assign dv_start = (state_q == S_DIV) && !sel_busy_q;
	assign out.valid = (state_q == S_OUT);

	logic [4:0] hc_clip;
	assign hc_clip = (cfg_q.hcount > 5'(MAXH > 6'd31 ? 6'd31 : MAXH) && MAXH <= 6'd31)
		? 5'(MAXH) : cfg_q.hcount;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sel_busy_q <= 1'b0;
			sel_c_q    <= 1'b0;
			h_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc_in && in.func == FUNC_EVAL) begin
						h_q <= HW'(1);
						state_q <= (hc_clip == 5'd0) ? S_DONE : S_READ;
					end
				end
				S_READ: begin
					state_q <= S_SIN0;
					sel_c_q <= 1'b0;
				end
				S_SIN0, S_SIN1: begin
					if (!sel_busy_q)
						sel_busy_q <= 1'b1;
					else if (sn_done) begin
						sel_busy_q <= 1'b0;
						sel_c_q <= 1'b1;
						state_q <= (state_q == S_SIN0) ? S_SIN1 : S_MUL;
					end
				end
				S_MUL:  state_q <= S_MUL2;
				S_MUL2: state_q <= S_DIV;
				S_DIV: begin
					if (!sel_busy_q)
						sel_busy_q <= 1'b1;
					else if (dv_done) begin
						sel_busy_q <= 1'b0;
						state_q <= S_ACC;
					end
				end
				S_ACC: state_q <= S_NEXT;
				S_NEXT: begin
					if (h_q >= n_q)
						state_q <= S_DONE;
					else begin
						h_q <= h_q + HW'(1);
						state_q <= S_READ;
					end
				end
				S_DONE: state_q <= S_OUT;
				S_OUT: if (out.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				k_q    <= in.tick_count;
				hk_q   <= in.tick_count;
				n_q    <= HW'(hc_clip);
				vsum_q <= '0;
				asum_q <= '0;
				psum_q <= {{16{cfg_q.offset[31]}}, cfg_q.offset, 16'd0};
			end
			S_READ: begin
				phase_q <= hk_q * cfg_q.phase_step;
			end
			S_SIN0, S_SIN1: begin
				// coefficient read lands on the first cycle of the sine pass
				if (!sel_busy_q && state_q == S_SIN0) begin
					a_q <= a_rd;
					b_q <= b_rd;
				end
				if (sel_busy_q && sn_done) begin
					if (state_q == S_SIN0) s_q <= qsel[1] ? -$signed(sn_y) : $signed(sn_y);
					else c_q <= qsel[1] ? -$signed(sn_y) : $signed(sn_y);
				end
			end
			S_MUL: begin
				pa_q <= 64'(a_q) * 64'(c_q);
				pb_q <= 64'(b_q) * 64'(s_q);
				pc_q <= 64'(a_q) * 64'(s_q);
				pd_q <= 64'(b_q) * 64'(c_q);
			end
			S_MUL2: begin
				vsum_q <= vsum_q + vel_t;
				tp_q <= fs32_p * $signed({32'd0, cfg_q.inv_omega});
				ta_q <= (fs32_a * $signed({32'd0, cfg_q.omega})) >>> 14;
			end
			S_ACC: begin
				psum_q <= psum_q + (dv_q >>> 14);
				asum_q <= asum_q + ta_q * $signed({{(64-HW){1'b0}}, h_q});
			end
			S_NEXT: hk_q <= hk_q + k_q;
			S_DONE: begin
				out.position     <= pos_w;
				out.velocity     <= vel_w;
				out.acceleration <= accn_w;
				out.saturated    <= p_c | v_c | a_c;
			end
			default: ;
		endcase
	end

	// assertions
	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in.ready) else $error("ready high while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && !out.ready) |=> out.valid) else $error("result dropped");
	a_h_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (h_q >= HW'(1) && h_q <= n_q)) else $error("harmonic range");
endmodule

FILE: bench/tb_fourier_trajectory_generator_unit.sv
// Testbench: checks the Fourier trajectory generator against an in-bench fixed-point predictor.
`timescale 1ns / 1ps
module tb_fourier_trajectory_generator_unit;
	import ftg_pkg::*;

	localparam int NHARM = MaxHarmonicsDefault;
	localparam int ABITS = SineAddrBitsDefault;
	localparam int CYCLE_LIMIT = 4000000;
	localparam logic [1:0] FUNC_RSVD = 2'd3;

	typedef struct {
		logic [1:0]  func;
		logic [3:0]  idx;
		logic [31:0] coef;
		logic [31:0] tick;
	} req_t;

	typedef struct {
		logic [31:0] pos;
		logic [31:0] vel;
		logic [31:0] acc;
		logic        sat;
	} traj_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_PHASE_STEP;
	logic [31:0] cfg_data = '0;

	ftg_in_if  in_ch();
	ftg_out_if out_ch();

	fourier_trajectory_generator_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in(in_ch), .out(out_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state: its own copy of registers and coefficient tables
	logic [31:0] m_step, m_omega, m_inv;
	logic signed [31:0] m_offset;
	logic [4:0] m_count;
	logic signed [31:0] m_cos [NHARM];
	logic signed [31:0] m_sin [NHARM];

	req_t  pending [$];
	traj_t expected [$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;  // no idling near the end
	bit hold = 1'b0;   // sender held off by the stimulus process
	bit taken = 1'b0;  // input beat accepted at the last rising edge

	// arithmetic shift is floor for signed values
	function automatic longint fl(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint qsin(longint unsigned x);
		longint unsigned x2, r, y;
		x2 = (x * x) >> 30;
		r = PC11;
		r = PC9 - ((x2 * r) >> 30);
		r = PC7 - ((x2 * r) >> 30);
		r = PC5 - ((x2 * r) >> 30);
		r = PC3 - ((x2 * r) >> 30);
		r = PC1 - ((x2 * r) >> 30);
		y = (x * r) >> 30;
		if (y > ONE_Q30) y = ONE_Q30;
		return longint'(y);
	endfunction

	function automatic longint quad_sin(logic [1:0] q, longint unsigned x);
		case (q)
			2'd0: return qsin(x);
			2'd1: return qsin(ONE_Q30 - x);
			2'd2: return -qsin(x);
			default: return -qsin(ONE_Q30 - x);
		endcase
	endfunction

	function automatic logic [31:0] clip32(longint v, ref logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	// applies one item to the predictor; returns 1 if it yields a trajectory sample
	function automatic bit predict_sample(req_t r, output traj_t t);
		int n;
		longint vs, ps, as_, a, b, s, c, w;
		logic [31:0] ph, p;
		logic sat;
		t = '{default: '0};
		if (r.func == FUNC_WR_COS || r.func == FUNC_WR_SIN) begin
			if (r.func == FUNC_WR_COS) m_cos[r.idx] = r.coef;
			else m_sin[r.idx] = r.coef;
			return 1'b0;
		end
		if (r.func != FUNC_EVAL) return 1'b0;
		n = (m_count > NHARM) ? NHARM : m_count;
		vs = 0; as_ = 0;
		ps = longint'(m_offset) * 65536;
		for (int h = 1; h <= n; h++) begin
			ph = (32'(h) * r.tick) * m_step;
			p = ph >> (32 - ABITS);
			s = quad_sin(p[ABITS-1 -: 2], longint'(p[ABITS-3:0]) << (32 - ABITS));
			c = quad_sin(p[ABITS-1 -: 2] + 2'd1, longint'(p[ABITS-3:0]) << (32 - ABITS));
			a = m_cos[h-1];
			b = m_sin[h-1];
			vs += fl(a * c + b * s, 22);
			w = fl(a * s - b * c, 32) * longint'({32'd0, m_inv});
			w = w / h;
			ps += fl(w, 14);
			w = fl(b * c - a * s, 32) * longint'({32'd0, m_omega});
			as_ += fl(w, 14) * h;
		end
		sat = 1'b0;
		t.pos = clip32(fl(ps, 16), sat);
		t.vel = clip32(fl(vs, 16), sat);
		t.acc = clip32(fl(as_, 16), sat);
		t.sat = sat;
		return 1'b1;
	endfunction

	// driver: one beat per pending item, random gaps, changes on the falling edge
	int gap = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (in_ch.valid && !taken) begin
			// beat still waiting, hold it
		end else begin
			if (in_ch.valid) void'(pending.pop_front());
			if (gap > 0) begin
				gap--;
				in_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(1, 17) - 1;
				in_ch.valid <= 1'b0;
			end else if (!hold && pending.size() > 0) begin
				req_t r;
				r = pending[0];
				in_ch.valid <= 1'b1;
				in_ch.func <= r.func;
				in_ch.coef_index <= r.idx;
				in_ch.coef_value <= r.coef;
				in_ch.tick_count <= r.tick;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// predictor sees each accepted beat at the rising edge
	always @(posedge clk) begin
		traj_t t;
		req_t r;
		taken <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			r = '{in_ch.func, in_ch.coef_index, in_ch.coef_value, in_ch.tick_count};
			if (predict_sample(r, t)) expected.push_back(t);
		end
	end

	// receiver stalls in bursts too
	int stall = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			out_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall = $urandom_range(1, 17) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		traj_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat pos=%h", out_ch.position);
			end else begin
				e = expected.pop_front();
				if (out_ch.position !== e.pos || out_ch.velocity !== e.vel ||
						out_ch.acceleration !== e.acc || out_ch.saturated !== e.sat) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp %h %h %h %b got %h %h %h %b",
							e.pos, e.vel, e.acc, e.sat, out_ch.position,
							out_ch.velocity, out_ch.acceleration, out_ch.saturated);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PHASE_STEP: m_step = val;
			REG_OMEGA: m_omega = val;
			REG_INV_OMEGA: m_inv = val;
			REG_OFFSET: m_offset = val;
			default: m_count = val[4:0];
		endcase
	endtask

	task automatic push_item(logic [1:0] f, logic [3:0] i, logic [31:0] v, logic [31:0] k);
		pending.push_back('{f, i, v, k});
	endtask

	// idle point: all beats sent, all results back, evaluation drained
	task automatic drain();
		while (pending.size() != 0 || in_ch.valid || expected.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 4))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
			default: return $urandom;
		endcase
	endfunction

	// one random phase: mostly coefficient loads and evaluations, a little noise
	task automatic random_phase(int count);
		for (int j = 0; j < count; j++) begin
			case ($urandom_range(0, 19))
				0: push_item(FUNC_RSVD, 4'($urandom), $urandom, $urandom);
				1, 2, 3, 4, 5, 6: push_item(FUNC_WR_COS, 4'($urandom), rand_coef(), $urandom);
				7, 8, 9, 10, 11, 12: push_item(FUNC_WR_SIN, 4'($urandom), rand_coef(), $urandom);
				default: push_item(FUNC_EVAL, 4'($urandom), $urandom,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom);
			endcase
		end
	endtask

	task automatic set_regs(logic [31:0] st, logic [31:0] om, logic [31:0] io,
			logic [31:0] off, logic [4:0] cnt);
		reg_write(REG_PHASE_STEP, st);
		reg_write(REG_OMEGA, om);
		reg_write(REG_INV_OMEGA, io);
		reg_write(REG_OFFSET, off);
		reg_write(REG_HCOUNT, {27'd0, cnt});
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_EVAL;
		in_ch.coef_index = '0;
		in_ch.coef_value = '0;
		in_ch.tick_count = '0;
		out_ch.ready = 1'b0;
		m_step = 32'd0;
		m_omega = 32'h0100_0000;
		m_inv = 32'h0100_0000;
		m_offset = 32'd0;
		m_count = 5'd16;
		for (int i = 0; i < NHARM; i++) begin
			m_cos[i] = 32'sd0;
			m_sin[i] = 32'sd0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: evaluate from reset tables, then extremes of coefficients
		push_item(FUNC_EVAL, 4'd0, 32'd0, 32'd0);
		push_item(FUNC_RSVD, 4'hf, 32'hffffffff, 32'hffffffff);  // unused func is dropped
		push_item(FUNC_WR_COS, 4'd0, 32'h7fffffff, 32'd0);
		push_item(FUNC_WR_SIN, 4'd0, 32'h80000000, 32'd0);
		push_item(FUNC_WR_COS, 4'd15, 32'h0100_0000, 32'd0);
		push_item(FUNC_WR_SIN, 4'd15, 32'hff00_0000, 32'd0);
		push_item(FUNC_EVAL, 4'd0, 32'd0, 32'd0);
		push_item(FUNC_EVAL, 4'hf, 32'hffffffff, 32'hffffffff);
		drain();
		set_regs(32'h4000_0000, 32'hffffffff, 32'hffffffff, 32'h7fffffff, 5'd16);
		push_item(FUNC_EVAL, 4'd0, 32'd0, 32'd1);
		push_item(FUNC_EVAL, 4'd0, 32'd0, 32'd3);
		push_item(FUNC_EVAL, 4'd0, 32'd0, 32'hffffffff);
		drain();
		// count zero sums nothing; count above the table size clamps to it
		set_regs(32'hffffffff, 32'd0, 32'd0, 32'h80000000, 5'd0);
		push_item(FUNC_EVAL, 4'd0, 32'd0, 32'd5);
		drain();
		reg_write(REG_HCOUNT, 32'd31);
		push_item(FUNC_EVAL, 4'd0, 32'd0, 32'd7);
		drain();

		// random phases under a spread of settings, ten and sixteen harmonics among them
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: set_regs($urandom, 32'h0100_0000, 32'h0100_0000, 32'd0, 5'd10);
				1: set_regs($urandom, $urandom, $urandom, $urandom, 5'd16);
				2: set_regs(32'h0100_0000, 32'h0040_0000, 32'h0400_0000, 32'h0001_0000, 5'd1);
				9: set_regs($urandom, $urandom_range(0, 32'h0800_0000),
					$urandom_range(0, 32'h0800_0000), $urandom, 5'd16);
				default: set_regs($urandom, $urandom, $urandom, $urandom,
					5'($urandom_range(0, 31)));
			endcase
			if (ph == 9) quiet = 1'b1;
			if (ph == 4) begin
				// sender waits for every outstanding result once, mid-phase
				random_phase(34);
				repeat (300) @(posedge clk);
				hold = 1'b1;
				while (expected.size() != 0 || in_ch.valid) @(posedge clk);
				hold = 1'b0;
				random_phase(34);
			end else begin
				random_phase(68);
			end
			drain();
		end

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
